[hdl/sfh_pkg.sv]
// Shared constants, register map and hash step functions for the bucket index block.
package sfh_pkg;

  localparam int unsigned WORD_W       = 32;
  localparam int unsigned KEY_LEN_W    = 16;
  localparam int unsigned CFG_ADDR_W   = 3;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned AVAL_STEPS   = 6;
  localparam int unsigned STEP_W       = 3;
  localparam int unsigned DIV_CNT_W    = 5;

  localparam logic [31:0] MAX_KEY_BYTES = 32'd65535;

  // Register index, taken from address bit 2 (byte address 4*i).
  localparam logic REG_TABLE_SIZE = 1'b0;

  localparam logic [WORD_W-1:0] TABLE_SIZE_RESET = 32'd1;

  typedef logic [WORD_W-1:0] word_t;

  function automatic word_t sext8(input logic [7:0] b);
    return {{24{b[7]}}, b};
  endfunction

  function automatic word_t mix_full(input word_t h_in, input word_t w);
    word_t h;
    word_t t;
    h = h_in + {16'd0, w[15:0]};
    t = ({16'd0, w[31:16]} << 11) ^ h;
    h = (h << 16) ^ t;
    h = h + (h >> 11);
    return h;
  endfunction

  function automatic word_t mix_tail(input word_t h_in, input word_t w, input logic [1:0] n);
    word_t h;
    h = h_in;
    unique case (n)
      2'd3: begin
        h = h + {16'd0, w[15:0]};
        h = h ^ (h << 16);
        h = h ^ (sext8(w[23:16]) << 18);
        h = h + (h >> 11);
      end
      2'd2: begin
        h = h + {16'd0, w[15:0]};
        h = h ^ (h << 11);
        h = h + (h >> 17);
      end
      2'd1: begin
        h = h + sext8(w[7:0]);
        h = h ^ (h << 10);
        h = h + (h >> 11);
      end
      default: h = h_in;
    endcase
    return h;
  endfunction

  // One shift-and-combine step of the final avalanche.
  function automatic word_t aval_step(input word_t h, input logic [STEP_W-1:0] idx);
    word_t r;
    unique case (idx)
      3'd0:    r = h ^ (h << 3);
      3'd1:    r = h + (h >> 5);
      3'd2:    r = h ^ (h << 4);
      3'd3:    r = h + (h >> 17);
      3'd4:    r = h ^ (h << 25);
      3'd5:    r = h + (h >> 6);
      default: r = h;
    endcase
    return r;
  endfunction

endpackage

[hdl/sfh_in_if.sv]
// Input channel carrying key words with their length and last mark.
interface sfh_in_if;
  import sfh_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [WORD_W-1:0]    key_word;
  logic [KEY_LEN_W-1:0] key_length;
  logic                 last_word;

  modport source (output valid, output key_word, output key_length, output last_word,
                  input ready);
  modport sink   (input valid, input key_word, input key_length, input last_word,
                  output ready);
endinterface

[hdl/sfh_out_if.sv]
// Result channel carrying the bucket index.
interface sfh_out_if;
  import sfh_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] bucket;

  modport source (output valid, output bucket, input ready);
  modport sink   (input valid, input bucket, output ready);
endinterface

[hdl/sfh_mod.sv]
// Restoring remainder unit: one quotient bit per cycle.
module sfh_mod (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  sfh_pkg::word_t      dividend,
  input  sfh_pkg::word_t      divisor,
  output logic                done,
  output sfh_pkg::word_t      rem
);
  import sfh_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  word_t                rem_r, rem_nxt;
  word_t                dvd_r, dvd_nxt;
  word_t                dsr_r, dsr_nxt;
  logic [WORD_W:0]      trial;
  logic [WORD_W:0]      diff;

  assign trial = {rem_r, dvd_r[WORD_W-1]};
  assign diff  = trial - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      // The remainder stays below the divisor, so it always fits one word.
      if (diff[WORD_W]) begin
        rem_nxt = trial[WORD_W-1:0];
      end else begin
        rem_nxt = diff[WORD_W-1:0];
      end
      dvd_nxt = dvd_r << 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == '1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && dsr_r != '0) |-> rem_r < dsr_r)
    else $error("remainder reached the divisor");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("done without a finished operation");

  a_no_restart_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("remainder unit started while busy");

endmodule

[hdl/superfasthash_bucket_index_top.sv]
// Streaming 32-bit SuperFastHash of a key reduced to a bucket index modulo table_size.
// A word that is not last is taken at once, and ready stays high for the next word.
// A last word goes through the mix, 6 avalanche steps on the shared shift/add unit,
// the bit-serial remainder unit and the finish state, which waits for a free output.
// Zero length or zero table size skips to the finish state with bucket zero. rst_n is synchronous
// and active low; it clears the sequencer, key state and output valid; table_size reads 1.
module superfasthash_bucket_index_top (
  input  logic                              clk,
  input  logic                              rst_n,
  sfh_in_if.sink                            in_ch,
  sfh_out_if.source                         out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [sfh_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [sfh_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [sfh_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);
  import sfh_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_AVAL = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  localparam logic [STEP_W-1:0] AVAL_LAST = STEP_W'(AVAL_STEPS - 1);

  logic [1:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              inside_r, inside_nxt;
  logic              empty_r, empty_nxt;
  logic [1:0]        tail_r, tail_nxt;
  word_t             hash_r, hash_nxt;
  word_t             res_r, res_nxt;
  word_t             tsize_r;
  logic              out_valid_r, out_valid_nxt;
  word_t             bucket_r, bucket_nxt;

  logic                 in_fire;
  logic                 first;
  logic [KEY_LEN_W-1:0] len_sat;
  word_t                seed;
  logic [1:0]           tail_cur;
  logic                 empty_cur;
  word_t                mixed;
  word_t                aval_out;
  logic                 mod_start;
  logic                 mod_done;
  word_t                mod_rem;
  logic                 cfg_wr;
  logic                 out_free;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // The first beat of a key seeds the hash with its (saturated) length.
  assign first   = !inside_r;
  assign len_sat = ({16'd0, in_ch.key_length} > MAX_KEY_BYTES) ? MAX_KEY_BYTES[KEY_LEN_W-1:0]
                                                               : in_ch.key_length;
  assign seed      = first ? {16'd0, len_sat} : hash_r;
  assign tail_cur  = first ? len_sat[1:0] : tail_r;
  assign empty_cur = first ? (len_sat == '0) : empty_r;

  always_comb begin
    if (empty_cur) begin
      mixed = seed;
    end else if (!in_ch.last_word || tail_cur == 2'd0) begin
      mixed = mix_full(seed, in_ch.key_word);
    end else begin
      mixed = mix_tail(seed, in_ch.key_word, tail_cur);
    end
  end

  assign aval_out  = aval_step(hash_r, step_r);
  assign mod_start = (state_r == ST_AVAL) && (step_r == AVAL_LAST);

  sfh_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (aval_out),
    .divisor  (tsize_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    inside_nxt    = inside_r;
    empty_nxt     = empty_r;
    tail_nxt      = tail_r;
    hash_nxt      = hash_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    bucket_nxt    = bucket_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          hash_nxt = mixed;
          if (!in_ch.last_word) begin
            inside_nxt = 1'b1;
            empty_nxt  = empty_cur;
            tail_nxt   = tail_cur;
          end else begin
            inside_nxt = 1'b0;
            empty_nxt  = 1'b0;
            tail_nxt   = 2'd0;
            if (empty_cur || tsize_r == '0) begin
              res_nxt   = '0;
              state_nxt = ST_FIN;
            end else begin
              step_nxt  = '0;
              state_nxt = ST_AVAL;
            end
          end
        end
      end
      ST_AVAL: begin
        hash_nxt = aval_out;
        step_nxt = step_r + 1'b1;
        if (step_r == AVAL_LAST) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (mod_done) begin
          res_nxt   = mod_rem;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          bucket_nxt    = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_TABLE_SIZE) ? tsize_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      inside_r    <= 1'b0;
      empty_r     <= 1'b0;
      tail_r      <= 2'd0;
      out_valid_r <= 1'b0;
      tsize_r     <= TABLE_SIZE_RESET;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      inside_r    <= inside_nxt;
      empty_r     <= empty_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr && cfg_paddr[2] == REG_TABLE_SIZE) begin
        tsize_r <= cfg_pwdata;
      end
    end
    hash_r   <= hash_nxt;
    res_r    <= res_nxt;
    bucket_r <= bucket_nxt;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.bucket = bucket_r;

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> state_r == ST_DIV)
    else $error("remainder finished outside the divide phase");

  a_aval_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    mod_start |=> state_r == ST_DIV)
    else $error("avalanche did not hand over to the remainder unit");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FIN)
    else $error("result appeared without the finish state");

  a_bucket_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && tsize_r != '0) |-> bucket_r < tsize_r)
    else $error("bucket not below table size");

endmodule

[tb/tb_top.sv]
// Testbench for the SuperFastHash bucket index block: directed, random and back-pressure tests.
module tb_top;
  import sfh_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 60;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 330;

  localparam logic [CFG_ADDR_W-1:0] ADDR_TABLE_SIZE = {REG_TABLE_SIZE, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED   = {~REG_TABLE_SIZE, 2'b00};

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  sfh_in_if  in_ch ();
  sfh_out_if out_ch ();

  superfasthash_bucket_index_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Shadow of the block's key state and table size.
  word_t          hash_acc;
  logic           key_open;
  logic [1:0]     tail_cnt;
  logic           key_is_empty;
  word_t          table_size_q;
  word_t          expected_buckets[$];

  int error_count;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_request;
  int idle_cycles;

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  function automatic word_t mix_word(word_t h, word_t w);
    word_t r;
    r = h + word_t'(w[15:0]);
    r = (r << 16) ^ (word_t'(w[31:16]) << 11) ^ r;
    r = r + (r >> 11);
    return r;
  endfunction

  // Single tail bytes are sign extended, as the hash has always done with chars.
  function automatic word_t mix_tail_bytes(word_t h, word_t w, logic [1:0] n);
    word_t r;
    r = h;
    case (n)
      2'd3: begin
        r += word_t'(w[15:0]);
        r ^= r << 16;
        r ^= {{24{w[23]}}, w[23:16]} << 18;
        r += r >> 11;
      end
      2'd2: begin
        r += word_t'(w[15:0]);
        r ^= r << 11;
        r += r >> 17;
      end
      2'd1: begin
        r += {{24{w[7]}}, w[7:0]};
        r ^= r << 10;
        r += r >> 11;
      end
      default: r = h;
    endcase
    return r;
  endfunction

  function automatic word_t avalanche(word_t h);
    word_t r;
    r = h;
    r ^= r << 3;
    r += r >> 5;
    r ^= r << 4;
    r += r >> 17;
    r ^= r << 25;
    r += r >> 6;
    return r;
  endfunction

  task automatic track_key_word(word_t w, logic [KEY_LEN_W-1:0] len, logic last);
    logic [31:0] len_sat;
    if (!key_open) begin
      len_sat      = (32'(len) > MAX_KEY_BYTES) ? MAX_KEY_BYTES : 32'(len);
      hash_acc     = len_sat;
      tail_cnt     = len_sat[1:0];
      key_is_empty = (len_sat == 32'd0);
      key_open     = 1'b1;
    end
    if (!key_is_empty) begin
      if (!last || tail_cnt == 2'd0) hash_acc = mix_word(hash_acc, w);
      else hash_acc = mix_tail_bytes(hash_acc, w, tail_cnt);
    end
    if (last) begin
      if (key_is_empty || table_size_q == '0) expected_buckets.push_back('0);
      else expected_buckets.push_back(avalanche(hash_acc) % table_size_q);
      hash_acc     = '0;
      key_open     = 1'b0;
      tail_cnt     = 2'd0;
      key_is_empty = 1'b0;
    end
  endtask

  // Entered just after a rising edge; returns at the edge that accepts the beat.
  task automatic send_word(word_t w, logic [KEY_LEN_W-1:0] len, logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid      <= 1'b0;
      in_ch.key_word   <= $urandom;
      in_ch.key_length <= KEY_LEN_W'($urandom);
      in_ch.last_word  <= 1'($urandom_range(1));
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.key_word   <= w;
    in_ch.key_length <= len;
    in_ch.last_word  <= last;
    do @(posedge clk); while (!in_ch.ready);
    track_key_word(w, len, last);
  endtask

  task automatic send_key(logic [KEY_LEN_W-1:0] len, int n_words, bit vary_len);
    for (int i = 0; i < n_words; i++)
      send_word($urandom, (vary_len && i > 0) ? KEY_LEN_W'($urandom) : len, i == n_words - 1);
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_buckets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == ADDR_TABLE_SIZE) table_size_q = data;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // With the reset table size of one, every bucket is zero.
  task automatic test_reset_table_size();
    send_word(32'h1234_5678, 16'd5, 1'b0);
    send_word(32'h0000_00AB, 16'd5, 1'b1);
    send_word(32'hFFFF_FFFF, 16'd0, 1'b0);
    send_word(32'hFFFF_FFFF, 16'd0, 1'b1);
  endtask

  task automatic test_tail_rules();
    wait_results_drained();
    write_reg(ADDR_TABLE_SIZE, 32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFF, 16'd0, 1'b1);
    send_word(32'hFFFF_FF80, 16'd1, 1'b1);
    send_word(32'hFFFF_FFFF, 16'd2, 1'b1);
    send_word(32'h7F80_FFFF, 16'd3, 1'b1);
    send_word(32'hFFFF_FFFF, 16'd4, 1'b1);
    send_word(32'h0000_0000, 16'd7, 1'b0);
    send_word(32'h00FF_8001, 16'd7, 1'b1);
  endtask

  // Maximum length with too few words, and a length that changes inside a key.
  task automatic test_length_corners();
    send_word(32'hA5A5_A5A5, 16'hFFFF, 1'b0);
    send_word(32'h5A5A_5A5A, 16'hFFFF, 1'b1);
    send_word(32'hDEAD_BEEF, 16'd6, 1'b0);
    send_word(32'h0BAD_F00D, 16'd0, 1'b0);
    send_word(32'hCAFE_8080, 16'hFFFF, 1'b1);
  endtask

  // A zero table size forces bucket zero; a write to an unmapped address changes nothing.
  task automatic test_table_size_corners();
    wait_results_drained();
    write_reg(ADDR_TABLE_SIZE, 32'd0);
    send_word(32'h8765_4321, 16'd4, 1'b1);
    wait_results_drained();
    write_reg(ADDR_UNMAPPED, 32'd7);
    send_word(32'h1111_1111, 16'd9, 1'b0);
    send_word(32'h2222_2222, 16'd9, 1'b0);
    send_word(32'h0000_0033, 16'd9, 1'b1);
  endtask

  // Mostly well-formed keys; the rest have a wrong word count or a changing length.
  task automatic test_random_keys(word_t table_size, int send_pct, int recv_pct, int n_items);
    int pick;
    int n_words;
    int sent;
    logic [KEY_LEN_W-1:0] len;
    wait_results_drained();
    write_reg(ADDR_TABLE_SIZE, table_size);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        len = ($urandom_range(9) == 0) ? KEY_LEN_W'($urandom_range(64)) :
                                         KEY_LEN_W'($urandom_range(16));
        n_words = (len == 0) ? $urandom_range(1, 2) : (int'(len) + 3) / 4;
        send_key(len, n_words, 1'b0);
      end else if (pick < 90) begin
        len = KEY_LEN_W'($urandom);
        n_words = $urandom_range(1, 4);
        send_key(len, n_words, 1'b0);
      end else begin
        len = $urandom_range(1, 12);
        n_words = $urandom_range(2, 4);
        send_key(len, n_words, 1'b1);
      end
      if (len != 0) sent += n_words;
    end
  endtask

  // The receiver holds off while short keys keep coming, so the block fills and stalls.
  task automatic test_backpressure();
    wait_results_drained();
    write_reg(ADDR_TABLE_SIZE, 32'd37);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = HOLD_CYCLES;
    for (int i = 0; i < 40; i++) send_key(KEY_LEN_W'($urandom_range(1, 4)), 1, 1'b0);
    wait_results_drained();
    for (int i = 0; i < 20; i++) send_key(KEY_LEN_W'($urandom_range(1, 8)), 2, 1'b0);
  endtask

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.key_word   = '0;
    in_ch.key_length = '0;
    in_ch.last_word  = 1'b0;
    cfg_psel         = 1'b0;
    cfg_penable      = 1'b0;
    cfg_pwrite       = 1'b0;
    cfg_paddr        = '0;
    cfg_pwdata       = '0;
    hash_acc         = '0;
    key_open         = 1'b0;
    tail_cnt         = 2'd0;
    key_is_empty     = 1'b0;
    table_size_q     = TABLE_SIZE_RESET;
    error_count      = 0;
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    hold_request     = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_table_size();
    test_tail_rules();
    test_length_corners();
    test_table_size_corners();
    test_random_keys(32'hFFFF_FFFF, 32, 64, PHASE_ITEMS);
    test_random_keys(word_t'($urandom_range(2, 1000)), 64, 32, PHASE_ITEMS);
    test_random_keys(word_t'($urandom), 0, 0, PHASE_ITEMS);
    test_backpressure();

    wait_results_drained();
    if (error_count == 0 && expected_buckets.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result receiver: random stalls, plus a long hold-off on request.
  initial begin : drive_out_ready
    int hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_buckets
    word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_buckets.size() == 0) begin
        $display("%0t: unexpected bucket beat %0d with nothing expected", $time, out_ch.bucket);
        error_count++;
      end else begin
        want = expected_buckets.pop_front();
        if (out_ch.bucket !== want) begin
          $display("%0t: bucket mismatch: expected %0d, actual %0d", $time, want, out_ch.bucket);
          error_count++;
        end
      end
    end
  end

  // Ends the run if no beat moves on any port for too long.
  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[superfasthash_bucket_index_top.f]
hdl/sfh_pkg.sv
hdl/sfh_in_if.sv
hdl/sfh_out_if.sv
hdl/sfh_mod.sv
hdl/superfasthash_bucket_index_top.sv
tb/tb_top.sv
